// File: hdl/nalsp_pkg.sv
// shared types and constants of the annex b nal splitter
package nalsp_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int NSLOT      = HOLD_DEPTH + 1;
  localparam int HCNT_W     = $clog2(HOLD_DEPTH + 1);
  localparam int HIDX_W     = $clog2(HOLD_DEPTH);
  localparam int SLOT_W     = $clog2(NSLOT);
  localparam int NRES_W     = $clog2(NSLOT + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [23:0] START_CODE = 24'h000001;

  localparam logic [4:0] TYPE_SLICE = 5'h01;
  localparam logic [4:0] TYPE_IDR   = 5'h05;
  localparam logic [4:0] TYPE_SPS   = 5'h07;
  localparam logic [4:0] TYPE_PPS   = 5'h08;

  // codes on the nal_kind output
  localparam logic [2:0] OUT_SLICE = 3'd0;
  localparam logic [2:0] OUT_IDR   = 3'd1;
  localparam logic [2:0] OUT_SPS   = 3'd2;
  localparam logic [2:0] OUT_PPS   = 3'd3;
  localparam logic [2:0] OUT_ERR   = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       first;
    logic       last;
    logic       cfg;
    logic       timed;
  } res_t;

  // all results that one input byte releases
  typedef struct packed {
    logic [NRES_W-1:0]   count;
    logic [30:0]         rel;
    res_t [NSLOT-1:0]    slot;
  } cmd_t;

endpackage

// File: hdl/nalsp_front.sv
// front end: start code search, nal classification and hold buffer
module nalsp_front
  import nalsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        last_of_buffer,
  input  logic        drop_slices,
  input  logic [31:0] pts_low,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  typedef enum logic [2:0] {K_DISCARD, K_SLICE, K_IDR, K_SPS, K_PPS} kind_t;

  function automatic logic [2:0] out_code(kind_t k);
    logic [2:0] c;
    c = OUT_SLICE;
    unique case (k)
      K_SLICE: c = OUT_SLICE;
      K_IDR:   c = OUT_IDR;
      K_SPS:   c = OUT_SPS;
      K_PPS:   c = OUT_PPS;
      default: c = OUT_SLICE;
    endcase
    return c;
  endfunction

  logic [7:0]        held_r   [HOLD_DEPTH];
  logic [7:0]        held_nxt [HOLD_DEPTH];
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [23:0]       hist_r, hist_nxt;
  kind_t             kind_r, kind_nxt;
  logic              sps_r, sps_nxt, pps_r, pps_nxt;
  logic              cfg_sent_r, cfg_sent_nxt;
  logic              tbv_r, tbv_nxt;
  logic [31:0]       tb_r, tb_nxt;
  logic              abort_r, abort_nxt;
  logic              fp_r, fp_nxt, cp_r, cp_nxt;

  always_comb begin
    logic [NRES_W-1:0] n;
    logic [HCNT_W-1:0] kk;
    logic [NRES_W-1:0] m;
    logic [7:0]        seq [NSLOT];
    logic              old_fwd, old_frame, new_frame, cp_new;
    kind_t             nk;
    logic [4:0]        ntype;
    logic [31:0]       diff;

    for (int i = 0; i < HOLD_DEPTH; i++) held_nxt[i] = held_r[i];
    hcnt_nxt     = hcnt_r;
    hist_nxt     = hist_r;
    kind_nxt     = kind_r;
    sps_nxt      = sps_r;
    pps_nxt      = pps_r;
    cfg_sent_nxt = cfg_sent_r;
    tbv_nxt      = tbv_r;
    tb_nxt       = tb_r;
    abort_nxt    = abort_r;
    fp_nxt       = fp_r;
    cp_nxt       = cp_r;
    cmd          = '0;
    n            = '0;
    kk           = '0;
    m            = '0;
    cp_new       = 1'b0;
    nk           = K_DISCARD;
    ntype        = data_byte[4:0];
    old_fwd      = (kind_r != K_DISCARD);
    old_frame    = (kind_r == K_SLICE) || (kind_r == K_IDR);
    new_frame    = 1'b0;
    for (int i = 0; i < HOLD_DEPTH; i++) seq[i] = (HCNT_W'(i) < hcnt_r) ? held_r[i] : data_byte;
    seq[NSLOT-1] = data_byte;

    if (acc) begin
      if (abort_r) begin
        if (last_of_buffer) begin
          hcnt_nxt  = '0;
          kind_nxt  = K_DISCARD;
          fp_nxt    = 1'b0;
          cp_nxt    = 1'b0;
          hist_nxt  = '0;
          abort_nxt = 1'b0;
        end
      end else if (hist_r == START_CODE) begin
        // flush the open nal without its start code and one leading zero
        kk = (hcnt_r >= HCNT_W'(3)) ? hcnt_r - HCNT_W'(3) : '0;
        if (kk != '0 && held_r[HIDX_W'(kk - HCNT_W'(1))] == 8'h00) kk = kk - HCNT_W'(1);
        if (!old_fwd) kk = '0;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
          if (HCNT_W'(i) < kk) begin
            cmd.slot[i].data  = held_r[i];
            cmd.slot[i].kind  = out_code(kind_r);
            cmd.slot[i].first = (i == 0) && fp_r;
            cmd.slot[i].last  = (HCNT_W'(i) == kk - HCNT_W'(1));
            cmd.slot[i].cfg   = (i == 0) && fp_r && cp_r;
            cmd.slot[i].timed = old_frame;
          end
        end
        n = NRES_W'(kk);

        priority if (ntype == TYPE_SPS) begin
          nk      = K_SPS;
          sps_nxt = 1'b1;
        end else if (ntype == TYPE_PPS) begin
          nk      = K_PPS;
          pps_nxt = 1'b1;
        end else if (ntype == TYPE_IDR) begin
          nk = K_IDR;
        end else if (ntype == TYPE_SLICE && !drop_slices) begin
          nk = K_SLICE;
        end else begin
          nk = K_DISCARD;
        end
        new_frame = (nk == K_SLICE) || (nk == K_IDR);

        if (new_frame && !cfg_sent_r && !(sps_r && pps_r)) begin
          // frame before parameter sets: error, skip rest of buffer
          for (int j = 0; j < NSLOT; j++) begin
            if (NRES_W'(j) == n) begin
              cmd.slot[j].data = 8'h00;
              cmd.slot[j].kind = OUT_ERR;
            end
          end
          n         = n + NRES_W'(1);
          hcnt_nxt  = '0;
          kind_nxt  = K_DISCARD;
          fp_nxt    = 1'b0;
          cp_nxt    = 1'b0;
          hist_nxt  = '0;
          abort_nxt = !last_of_buffer;
        end else begin
          if (new_frame && !cfg_sent_r) begin
            cfg_sent_nxt = 1'b1;
            cp_new       = 1'b1;
          end
          if (new_frame && !tbv_r) begin
            tbv_nxt = 1'b1;
            tb_nxt  = pts_low;
          end
          held_nxt[0] = data_byte;
          hcnt_nxt    = HCNT_W'(1);
          kind_nxt    = nk;
          fp_nxt      = 1'b1;
          cp_nxt      = cp_new;
          hist_nxt    = {16'h0000, data_byte};
          if (last_of_buffer) begin
            if (nk != K_DISCARD) begin
              for (int j = 0; j < NSLOT; j++) begin
                if (NRES_W'(j) == n) begin
                  cmd.slot[j].data  = data_byte;
                  cmd.slot[j].kind  = out_code(nk);
                  cmd.slot[j].first = 1'b1;
                  cmd.slot[j].last  = 1'b1;
                  cmd.slot[j].cfg   = cp_new;
                  cmd.slot[j].timed = new_frame;
                end
              end
              n = n + NRES_W'(1);
            end
            hcnt_nxt = '0;
            kind_nxt = K_DISCARD;
            fp_nxt   = 1'b0;
            cp_nxt   = 1'b0;
            hist_nxt = '0;
          end
        end
      end else begin
        hist_nxt = {hist_r[15:0], data_byte};
        if (hcnt_r != '0) begin
          // oldest byte leaves when the hold buffer is full, all leave at buffer end
          if (last_of_buffer) m = NRES_W'(hcnt_r) + NRES_W'(1);
          else if (hcnt_r == HCNT_W'(HOLD_DEPTH)) m = NRES_W'(1);
          if (!old_fwd) m = '0;
          for (int i = 0; i < NSLOT; i++) begin
            if (NRES_W'(i) < m) begin
              cmd.slot[i].data  = seq[i];
              cmd.slot[i].kind  = out_code(kind_r);
              cmd.slot[i].first = (i == 0) && fp_r;
              cmd.slot[i].last  = last_of_buffer && (NRES_W'(i) == m - NRES_W'(1));
              cmd.slot[i].cfg   = (i == 0) && fp_r && cp_r;
              cmd.slot[i].timed = old_frame;
            end
          end
          n = m;
          if (m != '0) begin
            fp_nxt = 1'b0;
            cp_nxt = 1'b0;
          end
          for (int i = 0; i < HOLD_DEPTH; i++) begin
            held_nxt[i] = (hcnt_r == HCNT_W'(HOLD_DEPTH)) ? seq[i+1] : seq[i];
          end
          hcnt_nxt = (hcnt_r == HCNT_W'(HOLD_DEPTH)) ? hcnt_r : hcnt_r + HCNT_W'(1);
        end
        if (last_of_buffer) begin
          hcnt_nxt = '0;
          kind_nxt = K_DISCARD;
          fp_nxt   = 1'b0;
          cp_nxt   = 1'b0;
          hist_nxt = '0;
        end
      end
    end

    diff      = pts_low - tb_nxt;
    cmd.rel   = diff[30:0];
    cmd.count = n;
    cmd_valid = acc && (n != '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HOLD_DEPTH; i++) held_r[i] <= held_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r     <= '0;
      hist_r     <= '0;
      kind_r     <= K_DISCARD;
      sps_r      <= 1'b0;
      pps_r      <= 1'b0;
      cfg_sent_r <= 1'b0;
      tbv_r      <= 1'b0;
      tb_r       <= '0;
      abort_r    <= 1'b0;
      fp_r       <= 1'b0;
      cp_r       <= 1'b0;
    end else begin
      hcnt_r     <= hcnt_nxt;
      hist_r     <= hist_nxt;
      kind_r     <= kind_nxt;
      sps_r      <= sps_nxt;
      pps_r      <= pps_nxt;
      cfg_sent_r <= cfg_sent_nxt;
      tbv_r      <= tbv_nxt;
      tb_r       <= tb_nxt;
      abort_r    <= abort_nxt;
      fp_r       <= fp_nxt;
      cp_r       <= cp_nxt;
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HCNT_W'(HOLD_DEPTH))
    else $error("hold count beyond depth");

  a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
    abort_r |-> (hcnt_r == '0 && kind_r == K_DISCARD))
    else $error("nal open while buffer aborted");

  a_cfg_after_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_sent_r |-> (sps_r && pps_r))
    else $error("config flagged before sps and pps");

endmodule

// File: hdl/nalsp_cmd_fifo.sv
// small queue of result commands between front and back end
module nalsp_cmd_fifo
  import nalsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/nalsp_back.sv
// back end: walks a command's results into the output register
module nalsp_back
  import nalsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_nal_kind,
  output logic        out_first_of_nal,
  output logic        out_last_of_nal,
  output logic [30:0] out_relative_time,
  output logic        out_config_first
);

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic              load;
  res_t              cur;
  res_t              res_r;
  logic [30:0]       rel_r;

  assign cur  = head.slot[idx_r];
  assign load = head_valid && (!valid_r || !out_stall);
  assign pop  = load && (NRES_W'(idx_r) == head.count - NRES_W'(1));

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = pop ? '0 : idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= cur;
      rel_r <= cur.timed ? head.rel : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_payload_byte  = res_r.data;
  assign out_nal_kind      = res_r.kind;
  assign out_first_of_nal  = res_r.first;
  assign out_last_of_nal   = res_r.last;
  assign out_relative_time = rel_r;
  assign out_config_first  = res_r.cfg;

endmodule

// File: hdl/annexb_nal_splitter_top.sv
// top level of the annex b nal splitter
//
// splits an h.264 annex b byte stream into nal payload bytes, one byte per
// transaction in and one result per transaction out. the front end takes one
// byte every clock cycle while in_stall is low and sorts it; results leave
// registered, at one per cycle while out_stall is low. a byte that ends a nal
// or a buffer can release up to six results at once (the five-byte hold
// buffer plus the byte itself); these sit in a four-entry command queue and
// drain one per cycle while out_stall is low, and in_stall rises only while
// that queue is full. so the sustained rate is one byte per cycle as long as,
// on average, a byte yields no more than one result and the output side takes
// them. there are no configuration registers and no clearing pass after reset.
module annexb_nal_splitter_top
  import nalsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_buffer,
  input  logic        in_drop_slices,
  input  logic [31:0] in_pts_low,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_nal_kind,
  output logic        out_first_of_nal,
  output logic        out_last_of_nal,
  output logic [30:0] out_relative_time,
  output logic        out_config_first
);

  logic in_acc;
  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_head_valid;
  cmd_t q_head;
  logic q_pop;

  // stall depends only on queue occupancy, never on in_valid
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  // start code search, nal typing, parameter set tracking, time base
  nalsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .data_byte      (in_data_byte),
    .last_of_buffer (in_last_of_buffer),
    .drop_slices    (in_drop_slices),
    .pts_low        (in_pts_low),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  // decouples bursts of results from the front end, which takes a byte per cycle while in_stall is low
  nalsp_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // one result per cycle into the output register while out_stall is low
  nalsp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head              (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_nal_kind      (out_nal_kind),
    .out_first_of_nal  (out_first_of_nal),
    .out_last_of_nal   (out_last_of_nal),
    .out_relative_time (out_relative_time),
    .out_config_first  (out_config_first)
  );

endmodule
